// ----- rtl/sat_pkg.sv -----
`default_nettype none

package sat_pkg;

  localparam int MAX_SEGMENTS = 16;
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);

  localparam logic [15:0] MEMORY_SIZE_RESET = 16'd16000;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_RANGE   = 2'd1;
  localparam logic [1:0] ST_OVERLAP = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // request under test, broadcast to every cell
  typedef struct packed {
    logic [15:0] base_addr;
    logic [16:0] end_addr;
    logic [15:0] length;
    logic        in_range;
  } sat_req_t;

endpackage

`default_nettype wire

// ----- rtl/sat_cell.sv -----
`default_nettype none

module sat_cell
  import sat_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        shift,
  input  wire logic        occupied,
  input  wire logic [15:0] base_in,
  input  wire logic [16:0] end_in,
  input  wire sat_req_t    req,
  output logic [15:0]      base_out,
  output logic [16:0]      end_out,
  output logic             hit
);

  logic [15:0] base_addr;
  logic [16:0] end_addr;

  always_ff @(posedge clk) begin
    if (shift) begin
      base_addr <= base_in;
      end_addr  <= end_in;
    end
    // half-open test: each segment starts below the other's end
    hit <= occupied && ({1'b0, req.base_addr} < end_addr) &&
           ({1'b0, base_addr} < req.end_addr);
  end

  assign base_out = base_addr;
  assign end_out  = end_addr;

endmodule

`default_nettype wire

// ----- rtl/sat_chain.sv -----
`default_nettype none

module sat_chain
  import sat_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             shift,
  input  wire logic [CNT_W-1:0] slot_count,
  input  wire sat_req_t         req,
  output logic                  hit_any
);

  logic [15:0] base_link [MAX_SEGMENTS+1];
  logic [16:0] end_link  [MAX_SEGMENTS+1];
  logic [MAX_SEGMENTS-1:0] hit;

  // newest segment enters cell 0, older ones move one cell down
  assign base_link[0] = req.base_addr;
  assign end_link[0]  = req.end_addr;

  for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
    sat_cell u_cell (
      .clk      (clk),
      .shift    (shift),
      .occupied (slot_count > CNT_W'(i)),
      .base_in  (base_link[i]),
      .end_in   (end_link[i]),
      .req      (req),
      .base_out (base_link[i+1]),
      .end_out  (end_link[i+1]),
      .hit      (hit[i])
    );
  end

  assign hit_any = |hit;

endmodule

`default_nettype wire

// ----- rtl/segment_allocation_table.sv -----
// Channel  Direction  Handshake            Beat
// req      in         req_valid/req_stall  seg_base, seg_length
// rsp      out        rsp_valid/rsp_stall  status, segment_id, free_memory, slots_used
// cfg      in         cfg_valid/cfg_ready  cfg_data -> memory_size
//
// One request at a time: capture with range check, a compare step in which all cells
// compare in parallel, and a resolve step that loads the result register.
// A held result stops the resolve step; a request is taken only in idle.
// rst is synchronous: empties the table, clears the total, memory_size = 16000.
// cfg_ready is always high.
`default_nettype none

module segment_allocation_table
  import sat_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire logic [15:0] seg_base,
  input  wire logic [15:0] seg_length,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output logic [1:0]       status,
  output logic [3:0]       segment_id,
  output logic [15:0]      free_memory,
  output logic [4:0]       slots_used,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_RES} state_t;

  state_t           state;
  sat_req_t         req;
  logic [15:0]      memory_size;
  logic [CNT_W-1:0] slot_count;
  logic [16:0]      allocated_total;

  logic             hit_any;
  logic             rsp_load;
  logic             table_full;
  logic             alloc;
  logic [1:0]       status_next;
  logic [CNT_W-1:0] slot_count_next;
  logic [16:0]      total_next;
  logic [16:0]      free_wide;
  logic [16:0]      end_calc;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != S_IDLE);

  assign end_calc   = {1'b0, seg_base} + {1'b0, seg_length};
  assign rsp_load   = (state == S_RES) && (!rsp_valid || !rsp_stall);
  assign table_full = (slot_count >= CNT_W'(MAX_SEGMENTS));

  always_comb begin
    if (!req.in_range) begin
      status_next = ST_RANGE;
    end else if (hit_any) begin
      status_next = ST_OVERLAP;
    end else if (table_full) begin
      status_next = ST_FULL;
    end else begin
      status_next = ST_OK;
    end
  end

  assign alloc           = rsp_load && (status_next == ST_OK);
  assign slot_count_next = (status_next == ST_OK) ? slot_count + CNT_W'(1) : slot_count;
  assign total_next      = (status_next == ST_OK) ?
                           allocated_total + {1'b0, req.length} : allocated_total;
  // saturates at zero when the size was lowered under the allocated total
  assign free_wide       = (total_next >= {1'b0, memory_size}) ?
                           17'd0 : {1'b0, memory_size} - total_next;

  sat_chain u_chain (
    .clk        (clk),
    .shift      (alloc),
    .slot_count (slot_count),
    .req        (req),
    .hit_any    (hit_any)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      rsp_valid       <= 1'b0;
      memory_size     <= MEMORY_SIZE_RESET;
      slot_count      <= '0;
      allocated_total <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        memory_size <= cfg_data;
      end
      if (rsp_valid && !rsp_stall && !rsp_load) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            req.base_addr <= seg_base;
            req.end_addr  <= end_calc;
            req.length    <= seg_length;
            req.in_range  <= (seg_base < memory_size) && (seg_length != 16'd0) &&
                             (end_calc < {1'b0, memory_size});
            state         <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_RES;
        end
        S_RES: begin
          if (rsp_load) begin
            rsp_valid       <= 1'b1;
            status          <= status_next;
            segment_id      <= (status_next == ST_OK) ? 4'(slot_count) : 4'd0;
            free_memory     <= free_wide[15:0];
            slots_used      <= 5'(slot_count_next);
            slot_count      <= slot_count_next;
            allocated_total <= total_next;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    slot_count <= CNT_W'(MAX_SEGMENTS))
    else $error("slot count beyond table depth");

  a_count_on_alloc: assert property (@(posedge clk) disable iff (rst)
    alloc |=> slot_count == $past(slot_count) + CNT_W'(1))
    else $error("allocation did not advance slot count");

  a_count_only_on_load: assert property (@(posedge clk) disable iff (rst)
    !rsp_load |=> slot_count == $past(slot_count))
    else $error("slot count moved without a result");

  a_id_zero_on_reject: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status != ST_OK) |-> segment_id == 4'd0)
    else $error("nonzero id on rejected request");
`endif

endmodule

`default_nettype wire

// ----- bench/alloc_checker.sv -----
`timescale 1ns / 100ps

module alloc_checker
  import sat_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_stall,
  input  logic [15:0] seg_base,
  input  logic [15:0] seg_length,
  input  logic        rsp_valid,
  input  logic        rsp_stall,
  input  logic [1:0]  status,
  input  logic [3:0]  segment_id,
  input  logic [15:0] free_memory,
  input  logic [4:0]  slots_used,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output int          errors,
  output int          awaiting
);

  typedef struct packed {
    logic [1:0]  st;
    logic [3:0]  id;
    logic [15:0] free;
    logic [4:0]  used;
  } placement_t;

  logic [15:0] mem_size;
  logic [15:0] slot_start [MAX_SEGMENTS];
  logic [15:0] slot_len   [MAX_SEGMENTS];
  logic [4:0]  fill_count;
  logic [16:0] alloc_total;
  placement_t  placement_results [$];

  initial begin
    errors   = 0;
    awaiting = 0;
  end

  function automatic placement_t place_segment(logic [15:0] b, logic [15:0] l);
    placement_t  r;
    logic [16:0] e;
    logic [16:0] se;
    logic        hit;
    int          i;
    e    = {1'b0, b} + l;
    r.id = '0;
    hit  = 1'b0;
    if (!(b < mem_size && l != 16'd0 && e < {1'b0, mem_size})) begin
      r.st = ST_RANGE;
    end else begin
      // half-open test: adjacent segments do not collide
      for (i = 0; i < MAX_SEGMENTS; i++) begin
        if (i < fill_count) begin
          se = {1'b0, slot_start[i]} + slot_len[i];
          if ({1'b0, b} < se && {1'b0, slot_start[i]} < e) hit = 1'b1;
        end
      end
      if (hit) begin
        r.st = ST_OVERLAP;
      end else if (fill_count >= MAX_SEGMENTS) begin
        r.st = ST_FULL;
      end else begin
        r.st = ST_OK;
        r.id = fill_count[3:0];
        slot_start[fill_count[3:0]] = b;
        slot_len[fill_count[3:0]]   = l;
        fill_count  = fill_count + 5'd1;
        alloc_total = alloc_total + l;
      end
    end
    // saturates when the size was lowered under the allocated total
    if (alloc_total >= {1'b0, mem_size}) r.free = '0;
    else r.free = mem_size - alloc_total[15:0];
    r.used = fill_count;
    return r;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s expected %0d got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    placement_t want;
    placement_t fresh;
    if (rst) begin
      mem_size    = MEMORY_SIZE_RESET;
      fill_count  = '0;
      alloc_total = '0;
      placement_results.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (placement_results.size() == 0) begin
          $error("result beat with no request outstanding");
          errors++;
        end else begin
          want = placement_results.pop_front();
          check_field("status", want.st, status);
          check_field("segment_id", want.id, segment_id);
          check_field("free_memory", want.free, free_memory);
          check_field("slots_used", want.used, slots_used);
        end
      end
      if (cfg_valid && cfg_ready) mem_size = cfg_data;
      if (req_valid && !req_stall) begin
        fresh = place_segment(seg_base, seg_length);
        placement_results = {placement_results, fresh};
      end
    end
    awaiting = placement_results.size();
  end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import sat_pkg::*;

  localparam int LIMIT = 600000;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        req_valid  = 1'b0;
  logic        req_stall;
  logic [15:0] seg_base   = '0;
  logic [15:0] seg_length = '0;
  logic        rsp_valid;
  logic        rsp_stall  = 1'b0;
  logic [1:0]  status;
  logic [3:0]  segment_id;
  logic [15:0] free_memory;
  logic [4:0]  slots_used;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data   = '0;

  int errors;
  int awaiting;
  int cycles     = 0;
  int items_sent = 0;
  int cur_size   = 16000;
  int recent_bases [$];

  always #1 clk = ~clk;

  segment_allocation_table dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .seg_base    (seg_base),
    .seg_length  (seg_length),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .status      (status),
    .segment_id  (segment_id),
    .free_memory (free_memory),
    .slots_used  (slots_used),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  alloc_checker chk (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .seg_base    (seg_base),
    .seg_length  (seg_length),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .status      (status),
    .segment_id  (segment_id),
    .free_memory (free_memory),
    .slots_used  (slots_used),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .awaiting    (awaiting)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("segment_allocation_table verification failed");
      $finish;
    end
  end

  // mostly short, now and then long
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_req(input logic [15:0] b, input logic [15:0] l);
    int gap;
    req_valid  <= 1'b1;
    seg_base   <= b;
    seg_length <= l;
    do @(posedge clk); while (req_stall);
    items_sent++;
    gap = pause_len();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    req_valid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
  endtask

  task automatic set_size(input int v);
    wait_idle();
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v[15:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_size = v;
  endtask

  task automatic random_req();
    int kind;
    int b;
    int l;
    int lim;
    kind = $urandom_range(0, 99);
    if (cur_size < 2 || kind < 15) begin
      b = $urandom;
      l = $urandom;
    end else if (kind < 60) begin
      b   = $urandom_range(0, cur_size - 2);
      lim = cur_size - 1 - b;
      if (lim > 64 && $urandom_range(0, 9) != 0) lim = 64;
      l = $urandom_range(1, lim);
      recent_bases = {recent_bases, b};
    end else if (kind < 80 && recent_bases.size() > 0) begin
      // land near an earlier segment to provoke collisions and touching edges
      b = recent_bases[$urandom_range(0, recent_bases.size() - 1)] + $urandom_range(0, 20) - 10;
      if (b < 0) b = 0;
      l = $urandom_range(1, 30);
    end else begin
      lim = (cur_size - 1 > 64) ? 64 : cur_size - 1;
      l   = $urandom_range(1, lim);
      b   = cur_size - l - $urandom_range(0, 2);
      if (b < 0) b = 0;
    end
    if (recent_bases.size() > 32) void'(recent_bases.pop_front());
    send_req(b[15:0], l[15:0]);
  endtask

  // result side: random stalls, plus one long hold-off so the request side backs up
  initial begin : rsp_side
    bit held;
    int run;
    held = 1'b0;
    forever begin
      if (!held && items_sent >= 300) begin
        held = 1'b1;
        rsp_stall <= 1'b1;
        repeat (500) @(posedge clk);
      end else if ($urandom_range(0, 19) == 0) begin
        rsp_stall <= 1'b0;
        repeat ($urandom_range(30, 80)) @(posedge clk);
      end else begin
        run = pause_len() + 1;
        rsp_stall <= ($urandom_range(0, 2) == 0);
        repeat (run) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int size_plan [5];
    int p;
    size_plan = '{16000, 65535, 0, 65535, 16000};
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // size still at its reset value
    send_req(16'd0, 16'd0);
    send_req(16'd0, 16'd16000);
    send_req(16'd15999, 16'd1);
    send_req(16'd15998, 16'd1);
    send_req(16'd65535, 16'd65535);
    send_req(16'd0, 16'd65535);
    send_req(16'd100, 16'd50);
    send_req(16'd150, 16'd10);
    send_req(16'd90, 16'd10);
    send_req(16'd120, 16'd5);
    send_req(16'd50, 16'd200);
    send_req(16'd149, 16'd2);

    set_size(65535);
    send_req(16'd60000, 16'd5534);
    send_req(16'd0, 16'd65534);
    send_req(16'd65534, 16'd1);

    set_size(0);
    send_req(16'd0, 16'd1);
    send_req(16'd0, 16'd0);

    set_size(1);
    send_req(16'd0, 16'd1);
    send_req(16'd0, 16'd0);

    // under the allocated total: free memory pins at zero
    set_size(100);
    send_req(16'd0, 16'd10);
    send_req(16'd95, 16'd4);
    send_req(16'd10, 16'd80);

    for (p = 0; p < 5; p++) begin
      if (p == 2) set_size($urandom_range(2, 65535));
      else set_size(size_plan[p]);
      repeat (150) random_req();
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("segment_allocation_table verification clean");
    end else begin
      $display("segment_allocation_table verification failed");
    end
    $finish;
  end

endmodule
